FILE: hw/rtl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C message transfer sequencer package
// Shared types, command and status bit positions, and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmts_pkg;

   localparam int unsigned ADDR_W   = 7;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned STATUS_W = 13;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CMD_W    = 10;
   localparam int unsigned POLL_W   = 11;

   localparam logic [POLL_W-1:0] POLL_LIMIT = 11'd2000;

   // Transaction kinds.
   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_STATUS  = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   // Result error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_IO        = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT   = 2'd2;
   localparam logic [1:0] ERR_NO_MSG    = 2'd3;

   // Command word bit positions.
   localparam int unsigned CMD_ADDR_BIT = 8;
   localparam int unsigned CMD_LAST_BIT = 9;

   // Controller status bits.
   localparam int unsigned ST_WR_FULL_BIT = 0;
   localparam int unsigned ST_RD_FULL_BIT = 1;
   localparam logic [STATUS_W-1:0] ST_ERR_MASK = 13'h00fc;
   localparam logic [STATUS_W-1:0] ST_RX_STATE = 13'h1800;

   typedef struct packed {
      logic [1:0]          mode;
      logic [ADDR_W-1:0]   target_address;
      logic                is_read;
      logic [COUNT_W-1:0]  byte_count;
      logic                final_message;
      logic [STATUS_W-1:0] status_word;
      logic [BYTE_W-1:0]   received_byte;
      logic [BYTE_W-1:0]   transmit_byte;
   } req_type;

   typedef struct packed {
      logic                command_valid;
      logic [CMD_W-1:0]    command_word;
      logic                byte_out_valid;
      logic [BYTE_W-1:0]   byte_out;
      logic [COUNT_W-1:0]  byte_position;
      logic                message_done;
      logic [1:0]          error_code;
   } rsp_type;

   typedef struct packed {
      logic                message_active;
      logic                direction_read;
      logic [COUNT_W-1:0]  bytes_left;
      logic [COUNT_W-1:0]  current_position;
      logic                awaiting_receive_state;
      logic [POLL_W-1:0]   poll_counter;
   } msg_state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cmts_step.sv
// ----------------------------------------------------------------------------
// I2C message transfer sequencer step
// Holds the message state and computes one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire i2cmts_pkg::req_type req,
   output i2cmts_pkg::rsp_type      rsp
);
   import i2cmts_pkg::*;

   msg_state_type state_ff;
   msg_state_type state_in;
   msg_state_type idle_state;

   logic [COUNT_W-1:0] left_dec;
   logic [POLL_W-1:0]  poll_inc;

   assign idle_state = '0;
   assign left_dec   = state_ff.bytes_left - COUNT_W'(1);
   assign poll_inc   = state_ff.poll_counter + POLL_W'(1);

   always_comb begin
      rsp      = '0;
      state_in = state_ff;
      case (req.mode)
         MODE_START: begin
            state_in                        = idle_state;
            state_in.message_active         = 1'b1;
            state_in.direction_read         = req.is_read;
            state_in.bytes_left             = req.byte_count;
            state_in.awaiting_receive_state = req.is_read && (req.byte_count == COUNT_W'(1));
            rsp.command_valid               = 1'b1;
            rsp.command_word[CMD_ADDR_BIT]  = 1'b1;
            rsp.command_word[7:0]           = {req.target_address, req.is_read};
            rsp.command_word[CMD_LAST_BIT]  = req.final_message &&
                                              (req.byte_count == '0);
         end
         MODE_STATUS, MODE_TIMEOUT: begin
            if (!state_ff.message_active) begin
               rsp.error_code = ERR_NO_MSG;
            end else if (req.mode == MODE_TIMEOUT) begin
               rsp.command_valid              = 1'b1;
               rsp.command_word[CMD_LAST_BIT] = 1'b1;
               rsp.message_done               = 1'b1;
               rsp.error_code                 = ERR_TIMEOUT;
               state_in                       = idle_state;
            end else if (state_ff.awaiting_receive_state) begin
               // One-byte read: each status event is only a poll of the receive state.
               if ((req.status_word & ST_RX_STATE) != '0) begin
                  rsp.command_valid               = 1'b1;
                  rsp.command_word[CMD_LAST_BIT]  = 1'b1;
                  state_in.awaiting_receive_state = 1'b0;
                  state_in.poll_counter           = '0;
               end else if (poll_inc >= POLL_LIMIT) begin
                  rsp.message_done = 1'b1;
                  rsp.error_code   = ERR_IO;
                  state_in         = idle_state;
               end else begin
                  state_in.poll_counter = poll_inc;
               end
            end else if ((req.status_word & ST_ERR_MASK) != '0) begin
               rsp.message_done = 1'b1;
               rsp.error_code   = ERR_IO;
               state_in         = idle_state;
            end else if (state_ff.direction_read) begin
               if (req.status_word[ST_RD_FULL_BIT]) begin
                  if (state_ff.bytes_left != '0) begin
                     rsp.byte_out_valid        = 1'b1;
                     rsp.byte_out              = req.received_byte;
                     rsp.byte_position         = state_ff.current_position;
                     state_in.bytes_left       = left_dec;
                     state_in.current_position = state_ff.current_position + COUNT_W'(1);
                     if (left_dec == COUNT_W'(1)) begin
                        rsp.command_valid              = 1'b1;
                        rsp.command_word[CMD_LAST_BIT] = 1'b1;
                     end else if (left_dec == '0) begin
                        rsp.message_done = 1'b1;
                        state_in         = idle_state;
                     end
                  end else begin
                     // A byte arrived that the message did not ask for.
                     rsp.message_done = 1'b1;
                     rsp.error_code   = ERR_IO;
                     state_in         = idle_state;
                  end
               end
            end else begin
               if (req.status_word[ST_WR_FULL_BIT]) begin
                  rsp.message_done = 1'b1;
                  rsp.error_code   = ERR_IO;
                  state_in         = idle_state;
               end else if (state_ff.bytes_left != '0) begin
                  rsp.command_valid              = 1'b1;
                  rsp.command_word[7:0]          = req.transmit_byte;
                  rsp.command_word[CMD_LAST_BIT] = (state_ff.bytes_left == COUNT_W'(1));
                  rsp.byte_position              = state_ff.current_position;
                  state_in.current_position      = state_ff.current_position + COUNT_W'(1);
                  state_in.bytes_left            = left_dec;
               end else begin
                  rsp.message_done = 1'b1;
                  state_in         = idle_state;
               end
            end
         end
         default: begin
            rsp      = '0;
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_message_transfer_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C message transfer sequencer
// Turns start, status and timeout transactions into controller commands.
// ----------------------------------------------------------------------------
// The block accepts one request transaction per clock cycle while req_stall is
// low and returns exactly one response transaction for each, in order. A request
// is captured in an input register; the message state is then updated and the
// response is written to the output register. The message state update sets the
// rate of one transaction per cycle. While a response waits under rsp_stall, one
// more request is taken into an empty input register before req_stall rises.
`default_nettype none

module i2c_message_transfer_sequencer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [6:0]  req_target_address,
   input  wire logic        req_is_read,
   input  wire logic [15:0] req_byte_count,
   input  wire logic        req_final_message,
   input  wire logic [12:0] req_status_word,
   input  wire logic [7:0]  req_received_byte,
   input  wire logic [7:0]  req_transmit_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_command_valid,
   output logic [9:0]       rsp_command_word,
   output logic             rsp_byte_out_valid,
   output logic [7:0]       rsp_byte_out,
   output logic [15:0]      rsp_byte_position,
   output logic             rsp_message_done,
   output logic [1:0]       rsp_error_code
);
   import i2cmts_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;
   req_type req_bundle;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type step_rsp;
   logic    out_blocked;
   logic    advance;
   logic    req_take;

   assign req_bundle = '{
      mode:           req_mode,
      target_address: req_target_address,
      is_read:        req_is_read,
      byte_count:     req_byte_count,
      final_message:  req_final_message,
      status_word:    req_status_word,
      received_byte:  req_received_byte,
      transmit_byte:  req_transmit_byte
   };

   assign out_blocked = out_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign out_valid_in = advance || out_blocked;

   i2cmts_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_req_ff),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_bundle;
      end
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command_valid  = out_rsp_ff.command_valid;
   assign rsp_command_word   = out_rsp_ff.command_word;
   assign rsp_byte_out_valid = out_rsp_ff.byte_out_valid;
   assign rsp_byte_out       = out_rsp_ff.byte_out;
   assign rsp_byte_position  = out_rsp_ff.byte_position;
   assign rsp_message_done   = out_rsp_ff.message_done;
   assign rsp_error_code     = out_rsp_ff.error_code;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// I2C message transfer sequencer checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_command_valid,
   input wire logic [9:0]  rsp_command_word,
   input wire logic        rsp_byte_out_valid,
   input wire logic [7:0]  rsp_byte_out,
   input wire logic        rsp_message_done,
   input wire logic [1:0]  rsp_error_code
);
   import i2cmts_pkg::*;

   // The response channel comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_word)
         && $stable(rsp_byte_out) && $stable(rsp_error_code))
      else $error("stalled response changed");

   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_command_valid |-> rsp_command_word == '0)
      else $error("command word without command");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_out_valid |-> rsp_byte_out == '0)
      else $error("received byte without delivery");

   // With no message in progress nothing else may be reported.
   a_no_msg_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NO_MSG |->
         !rsp_command_valid && !rsp_byte_out_valid && !rsp_message_done)
      else $error("activity on an event with no message");

endmodule

bind i2c_message_transfer_sequencer_top i2cmts_checker u_i2cmts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_command_valid  (rsp_command_valid),
   .rsp_command_word   (rsp_command_word),
   .rsp_byte_out_valid (rsp_byte_out_valid),
   .rsp_byte_out       (rsp_byte_out),
   .rsp_message_done   (rsp_message_done),
   .rsp_error_code     (rsp_error_code)
);

`default_nettype wire
